FILE: sv/rmte_pkg.sv
// ----------------------------------------------------------------------------
// rmte_pkg
// Shared widths, pipeline depths, stage types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package rmte_pkg;

  localparam int DW            = 18;  // matrix entry width
  localparam int TW            = 17;  // threshold width
  localparam int OPW           = 19;  // atan2 operand width (room for negation)
  localparam int XYW           = 34;  // CORDIC x/y datapath width
  localparam int ZW            = 26;  // angle accumulator, degrees Q.16
  localparam int PRESCALE_SH   = 12;
  localparam int SQRT_ITERS    = 17;
  localparam int SQRT_PER_STG  = 3;
  localparam int SQRT_STGS     = 6;
  localparam int CORDIC_ITERS  = 20;
  localparam int CORDIC_PER_STG = 2;
  localparam int CORDIC_LAT    = 11;  // pre-rotation stage plus iteration stages
  localparam int TOTAL_STGS    = 2 + SQRT_STGS + CORDIC_LAT;
  localparam int ANG_SH        = 8;   // Q.16 degrees down to 1/256 degree
  localparam logic signed [DW-1:0] LIM_180 = 18'sd46080;
  localparam logic signed [DW-1:0] LIM_90  = 18'sd23040;
  localparam logic signed [ZW-1:0] Z_90    = 26'sd5898240;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
    26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
    26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
  };

  typedef struct packed {
    logic signed [XYW-1:0] x;
    logic signed [XYW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  zero;
  } cordic_stg_t;

  // Round half up to 1/256 degree, then clamp to +-lim.
  function automatic logic signed [DW-1:0] sat_angle(logic signed [ZW-1:0] z,
                                                     logic signed [DW-1:0] lim);
    logic signed [ZW:0]   zr;
    logic signed [ZW:0]   r;
    logic signed [DW-1:0] res;
    zr = ZW'(0) + (ZW+1)'(z) + (ZW+1)'(128);
    r  = zr >>> ANG_SH;
    if (r > (ZW+1)'(lim)) begin
      res = lim;
    end else if (r < -(ZW+1)'(lim)) begin
      res = -lim;
    end else begin
      res = r[DW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/rmte_cordic.sv
// ----------------------------------------------------------------------------
// rmte_cordic
// Pipelined atan2 in vectoring mode: one pre-rotation stage, then two
// iterations per stage. Result in degrees, 16 fraction bits.
// ----------------------------------------------------------------------------
module rmte_cordic import rmte_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [OPW-1:0] y_i,
  input  logic signed [OPW-1:0] x_i,
  output logic signed [ZW-1:0]  z_o
);

  cordic_stg_t st_q [CORDIC_LAT];
  cordic_stg_t st_d [CORDIC_LAT];

  // Pre-rotation into the right half plane
  always_comb begin
    logic signed [XYW-1:0] xs;
    logic signed [XYW-1:0] ys;
    xs = {{(XYW-OPW-PRESCALE_SH){x_i[OPW-1]}}, x_i, {PRESCALE_SH{1'b0}}};
    ys = {{(XYW-OPW-PRESCALE_SH){y_i[OPW-1]}}, y_i, {PRESCALE_SH{1'b0}}};
    st_d[0].zero = (x_i == '0) && (y_i == '0);
    if (xs < 0) begin
      if (ys >= 0) begin
        st_d[0].x = ys;
        st_d[0].y = -xs;
        st_d[0].z = Z_90;
      end else begin
        st_d[0].x = -ys;
        st_d[0].y = xs;
        st_d[0].z = -Z_90;
      end
    end else begin
      st_d[0].x = xs;
      st_d[0].y = ys;
      st_d[0].z = '0;
    end
  end

  for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_iter
    always_comb begin
      cordic_stg_t           cur;
      logic signed [XYW-1:0] dx;
      logic signed [XYW-1:0] dy;
      int                    i;
      cur = st_q[k-1];
      for (int m = 0; m < CORDIC_PER_STG; m++) begin
        i  = (k - 1) * CORDIC_PER_STG + m;
        dx = cur.y >>> i;
        dy = cur.x >>> i;
        if (cur.y > 0) begin
          cur.x = cur.x + dx;
          cur.y = cur.y - dy;
          cur.z = cur.z + ATAN_TAB[i];
        end else begin
          cur.x = cur.x - dx;
          cur.y = cur.y + dy;
          cur.z = cur.z - ATAN_TAB[i];
        end
      end
      st_d[k] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign z_o = st_q[CORDIC_LAT-1].zero ? '0 : st_q[CORDIC_LAT-1].z;

endmodule

FILE: sv/rotation_matrix_to_euler_xyz_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_xyz_core
// Rotation matrix (Q1.16) to X-Y-Z Euler angles in 1/256 degree.
// ----------------------------------------------------------------------------
// Fully pipelined: one request enters per clock while the output is not
// stalled, and its result passes through twenty register stages (input
// register, squaring stage, six integer square root stages of up to three
// digits each, three parallel CORDIC atan2 units of eleven stages, output
// register). The whole pipe advances together whenever the output register
// is empty or being taken, so a stalled output holds every stage in place.
// Pitch = atan2(clamped r02, sqrt(1 - r02^2)); if that cosine exceeds
// cos_pitch_threshold, roll = atan2(-r12, r22) and yaw = atan2(-r01, r00),
// else roll = atan2(r21, r11) and yaw = 0. The user must write the threshold
// through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_xyz_core import rmte_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_wdata_i,      // cos_pitch_threshold, Q1.16
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // r00 [17:0], r01 [35:18], r02 [53:36], r11 [71:54], r12 [89:72],
  // r21 [107:90], r22 [125:108], zero pad [127:126]
  input  logic [127:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // roll_x [16:0], pitch_y [32:17], yaw_z [49:33], zero pad [55:50]
  output logic [55:0]   m_axis_tdata_o
);

  typedef struct packed {
    logic signed [DW-1:0] r00, r01, r11, r12, r21, r22;
  } side_t;

  typedef struct packed {
    logic [33:0]          n;
    logic [33:0]          res;
    logic signed [DW-1:0] s;
    side_t                side;
  } sqrt_stg_t;

  logic                 en;
  logic [TW-1:0]        thr_q;
  logic [TOTAL_STGS-1:0] v_q;

  // Stage 0: input register
  side_t                in_side_q;
  logic signed [DW-1:0] in_r02_q;

  // Stage 1: clamp and square
  logic signed [DW-1:0] s_clamp;
  logic [16:0]          s_abs;
  logic [33:0]          s_sq;
  logic [32:0]          rad_q;
  logic signed [DW-1:0] s_q;
  side_t                side_q;

  // Square root pipe
  sqrt_stg_t sq_q [SQRT_STGS];
  sqrt_stg_t sq_d [SQRT_STGS];
  sqrt_stg_t sq_last;

  // Operand select and CORDIC
  logic [16:0]           c_val;
  logic                  hi_cos;
  logic signed [OPW-1:0] py, px, ry, rx, yy, yx;
  logic signed [ZW-1:0]  pz, rz, yz;
  logic [CORDIC_LAT-1:0] lock_q;

  // Output register
  logic                  out_valid_q;
  logic [16:0]           roll_q;
  logic [15:0]           pitch_q;
  logic [16:0]           yaw_q;
  logic signed [DW-1:0]  roll_s, pitch_s, yaw_s;

  // The whole pipe moves when the output slot can take a new word
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[TOTAL_STGS-2:0], s_axis_tvalid_i};
      out_valid_q <= v_q[TOTAL_STGS-1];
    end
  end

  // Clamp r02 to +-one and square it
  always_comb begin
    if (in_r02_q > 18'sd65536) begin
      s_clamp = 18'sd65536;
    end else if (in_r02_q < -18'sd65536) begin
      s_clamp = -18'sd65536;
    end else begin
      s_clamp = in_r02_q;
    end
    s_abs = s_clamp[DW-1] ? 17'(-s_clamp) : s_clamp[16:0];
    s_sq  = 34'(s_abs) * 34'(s_abs);
  end

  // Digit-by-digit integer square root, up to three digits per stage
  for (genvar k = 0; k < SQRT_STGS; k++) begin : g_sqrt
    always_comb begin
      sqrt_stg_t   cur;
      logic [33:0] bitv;
      logic [33:0] trial;
      int          j;
      cur = sq_q[(k == 0) ? 0 : k - 1];
      if (k == 0) begin
        cur.n    = {1'b0, rad_q};
        cur.res  = '0;
        cur.s    = s_q;
        cur.side = side_q;
      end
      for (int m = 0; m < SQRT_PER_STG; m++) begin
        j = k * SQRT_PER_STG + m;
        if (j < SQRT_ITERS) begin
          bitv  = 34'(1) << (32 - 2 * j);
          trial = cur.res + bitv;
          if (cur.n >= trial) begin
            cur.n   = cur.n - trial;
            cur.res = (cur.res >> 1) + bitv;
          end else begin
            cur.res = cur.res >> 1;
          end
        end
      end
      sq_d[k] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_side_q <= '{r00: s_axis_tdata_i[17:0],   r01: s_axis_tdata_i[35:18],
                     r11: s_axis_tdata_i[71:54],  r12: s_axis_tdata_i[89:72],
                     r21: s_axis_tdata_i[107:90], r22: s_axis_tdata_i[125:108]};
      in_r02_q  <= s_axis_tdata_i[53:36];
      rad_q     <= 33'h1_0000_0000 - s_sq[32:0];
      s_q       <= s_clamp;
      side_q    <= in_side_q;
      sq_q      <= sq_d;
    end
  end

  // Branch select on cos(pitch) against the threshold
  assign sq_last = sq_q[SQRT_STGS-1];
  assign c_val   = sq_last.res[16:0];
  assign hi_cos  = c_val > thr_q;

  assign py = OPW'(sq_last.s);
  assign px = {2'b00, c_val};
  assign ry = hi_cos ? -OPW'(sq_last.side.r12) : OPW'(sq_last.side.r21);
  assign rx = hi_cos ?  OPW'(sq_last.side.r22) : OPW'(sq_last.side.r11);
  assign yy = -OPW'(sq_last.side.r01);
  assign yx =  OPW'(sq_last.side.r00);

  rmte_cordic u_pitch (.clk_i(clk_i), .en_i(en), .y_i(py), .x_i(px), .z_o(pz));
  rmte_cordic u_roll  (.clk_i(clk_i), .en_i(en), .y_i(ry), .x_i(rx), .z_o(rz));
  rmte_cordic u_yaw   (.clk_i(clk_i), .en_i(en), .y_i(yy), .x_i(yx), .z_o(yz));

  assign roll_s  = sat_angle(rz, LIM_180);
  assign pitch_s = sat_angle(pz, LIM_90);
  assign yaw_s   = sat_angle(yz, LIM_180);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lock_q  <= {lock_q[CORDIC_LAT-2:0], !hi_cos};
      roll_q  <= roll_s[16:0];
      pitch_q <= pitch_s[15:0];
      yaw_q   <= lock_q[CORDIC_LAT-1] ? '0 : yaw_s[16:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, yaw_q, pitch_q, roll_q};

`ifndef SYNTHESIS
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(pitch_q) <= 16'sd23040 && $signed(pitch_q) >= -16'sd23040))
    else $error("pitch out of range");
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(roll_q) <= 17'sd46080 && $signed(roll_q) >= -17'sd46080))
    else $error("roll out of range");
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(yaw_q) <= 17'sd46080 && $signed(yaw_q) >= -17'sd46080))
    else $error("yaw out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q) && $stable(roll_q) && $stable(yaw_q))
    else $error("pipe moved during stall");
`endif

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotation matrix to X-Y-Z Euler angle core.
// Requests carry seven matrix entries; a scoreboard predicts roll, pitch and
// yaw with a bit-exact integer CORDIC model and compares each response in
// order, under several threshold settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmte_pkg::*;

  localparam int NUM_RAND = 1150;
  localparam int ONE      = 65536;

  typedef struct packed {
    logic signed [16:0] yaw;
    logic signed [15:0] pitch;
    logic signed [16:0] roll;
  } angles_t;

  // CORDIC angle table, degrees Q.16
  localparam longint ATAN_DEG [20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // --------------------------------------------------------------------------
  // Predictor and in-order store of expected angle triples
  // --------------------------------------------------------------------------
  class euler_scoreboard;
    angles_t pending_angles[$];
    logic [16:0] cos_thr;
    int mismatches;

    function longint asr_floor(longint v, int s);
      return v >>> s;
    endfunction

    function longint isqrt(longint n);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint atan2_deg(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 4096;
      y = y * 4096;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 90 * 65536;
        end else begin
          t = x; x = -y; y = t; z = -90 * 65536;
        end
      end
      for (int i = 0; i < 20; i++) begin
        dx = asr_floor(y, i);
        dy = asr_floor(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z += ATAN_DEG[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_DEG[i];
        end
      end
      return z;
    endfunction

    function longint to_units(longint z, longint lim_deg);
      longint r, lim;
      lim = lim_deg * 256;
      r = (z + 128) >>> 8;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    // Note an accepted request and push its expected angles
    function void note_request(logic signed [17:0] m[7]);
      longint s, c, roll, pitch, yaw;
      angles_t a;
      s = m[2];
      if (s > ONE) s = ONE;
      if (s < -ONE) s = -ONE;
      c = isqrt(longint'(ONE) * ONE - s * s);
      pitch = atan2_deg(s, c);
      if (c > longint'(cos_thr)) begin
        roll = atan2_deg(-longint'(m[4]), m[6]);
        yaw  = atan2_deg(-longint'(m[1]), m[0]);
      end else begin
        roll = atan2_deg(m[5], m[3]);
        yaw  = 0;
      end
      a.roll  = 17'(to_units(roll, 180));
      a.pitch = 16'(to_units(pitch, 90));
      a.yaw   = 17'(to_units(yaw, 180));
      pending_angles.push_back(a);
    endfunction

    function void check_response(logic [55:0] d);
      angles_t e, g;
      g = d[49:0];
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", d);
        return;
      end
      e = pending_angles.pop_front();
      if (g.roll !== e.roll || g.pitch !== e.pitch || g.yaw !== e.yaw ||
          d[55:50] !== 6'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                   e.roll, e.pitch, e.yaw, g.roll, g.pitch, g.yaw);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [16:0]   cfg_wdata_i;
  logic          s_axis_tvalid_i;
  logic          s_axis_tready_o;
  logic [127:0]  s_axis_tdata_i;   // r00,r01,r02,r11,r12,r21,r22 (18 b each), pad
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i;
  logic [55:0]   m_axis_tdata_o;   // roll_x [16:0], pitch_y [32:17], yaw_z [49:33]

  rotation_matrix_to_euler_xyz_core dut (.*);

  euler_scoreboard sb;
  int send_idle_pct;   // sender gap chance per cycle
  int recv_stall_pct;  // receiver stall chance per cycle

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous fixed limit: far above the slowest legal run
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Response side: random stalls, check at each accepted edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_response(m_axis_tdata_o);
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic signed [17:0] rand_entry();
    case ($urandom_range(9))
      0: return 18'($urandom);                  // any pattern, out of range too
      1: return 18'sd65536;
      2: return -18'sd65536;
      3: return 18'sd0;
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // One request: optional idle gap, then hold until accepted.
  // Valid stays high after acceptance; the next gap or the caller drops it.
  task automatic send_matrix(logic signed [17:0] m[7]);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(m);
  endtask

  // Drain, then write the threshold while idle
  task automatic set_threshold(logic [16:0] thr);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (TOTAL_STGS + 4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.cos_thr = thr;
  endtask

  // Random matrix: each entry drawn from rand_entry
  task automatic send_random();
    logic signed [17:0] m[7];
    for (int k = 0; k < 7; k++) m[k] = rand_entry();
    // near gimbal lock now and then
    if ($urandom_range(4) == 0)
      m[2] = 18'($signed($urandom_range(200)) + (($urandom_range(1) != 0) ? 65336 : -65536));
    send_matrix(m);
  endtask

  initial begin
    logic signed [17:0] m[7];
    logic [16:0] thr_set[6];
    sb = new();
    sb.cos_thr = 17'd0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, extremes, clamp, zero vectors, gimbal lock
    m = '{18'sd65536, 0, 0, 18'sd65536, 0, 0, 18'sd65536};
    send_matrix(m);
    m = '{-18'sd65536, -18'sd65536, 18'sd65536, -18'sd65536, -18'sd65536,
          -18'sd65536, -18'sd65536};
    send_matrix(m);
    m = '{0, 0, -18'sd65536, 0, 0, 0, 0};
    send_matrix(m);
    m = '{18'sh1FFFF, 18'sh20000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF,
          18'sh20000, 18'sh1FFFF};
    send_matrix(m);
    m = '{18'sh20000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF, 18'sh20000,
          18'sh1FFFF, 18'sh20000};
    send_matrix(m);
    m = '{-18'sd65536, 0, 0, 0, 18'sd1, -18'sd65536, 18'sd65536};
    send_matrix(m);
    m = '{-18'sd1, 18'sd1, 18'sd46341, 18'sd46341, -18'sd46341, 18'sd1, -18'sd1};
    send_matrix(m);
    m = '{0, -18'sd1, 18'sd65535, -18'sd1, 0, 18'sd1, 0};
    send_matrix(m);
    for (int k = 0; k < 10; k++) send_random();

    thr_set = '{17'd65536, 17'd0, 17'd1, 17'd46341, 17'd65535,
                17'($urandom_range(65536))};
    for (int ph = 0; ph < 6; ph++) begin
      set_threshold(thr_set[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int k = 0; k < NUM_RAND / 6; k++) send_random();
    end

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (TOTAL_STGS + 10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rmte_pkg.sv
sv/rmte_cordic.sv
sv/rotation_matrix_to_euler_xyz_core.sv
dv/tb_top.sv
